// ----- rtl/lav_pkg.sv -----
// ---------------------------------------------------------------------------
// Look-at view matrix: shared package
// Widths, row codes and the saturation helper used across the pipeline.
// ---------------------------------------------------------------------------
package lav_pkg;

    localparam int FRAC_BITS_DEF = 16;   // default fraction bits (Q16.16)
    localparam int DATA_BITS     = 32;   // width of every coordinate port
    localparam int NORM_BITS     = 30;   // scaled magnitudes lie in [2^29, 2^30)
    localparam int SUM_BITS      = 2 * NORM_BITS + 2;  // sum of three squares
    localparam int ROOT_BITS     = SUM_BITS / 2;       // width of the length
    localparam int WIDE_BITS     = 40;   // rounded dot products before clamping

    typedef logic [1:0] row_t;

    localparam row_t ROW_X     = 2'd0;
    localparam row_t ROW_Y     = 2'd1;
    localparam row_t ROW_Z     = 2'd2;
    localparam row_t ROW_TRANS = 2'd3;

    // Clamp a signed value to the signed 32-bit range.
    function automatic logic signed [DATA_BITS-1:0] sat32(
        input logic signed [WIDE_BITS-1:0] v
    );
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'(32'sh7FFF_FFFF);
        lo = WIDE_BITS'(32'sh8000_0000);
        if (v > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return DATA_BITS'(v);
    endfunction

endpackage

// ----- rtl/lav_sqrt.sv -----
// ---------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage; floor(sqrt) of a SUM_BITS radicand.
// ---------------------------------------------------------------------------
module lav_sqrt #(
    parameter int TW = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [lav_pkg::SUM_BITS-1:0]  radicand,
    input  logic [TW-1:0]                 in_tag,
    output logic                          out_valid,
    output logic [lav_pkg::ROOT_BITS-1:0] root,
    output logic [TW-1:0]                 out_tag
);
    import lav_pkg::*;

    localparam int R  = ROOT_BITS;
    localparam int RW = ROOT_BITS + 3;   // remainder with two new bits

    logic [RW-1:0]       rem_w  [0:R];
    logic [R-1:0]        root_w [0:R];
    logic [SUM_BITS-1:0] x_w    [0:R];
    logic [TW-1:0]       tag_w  [0:R];
    logic                v_w    [0:R];

    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign x_w[0]    = radicand;
    assign tag_w[0]  = in_tag;
    assign v_w[0]    = in_valid;

    for (genvar k = 0; k < R; k++)
    begin : g_stage
        logic [RW-1:0]       rem_sh;
        logic [RW-1:0]       trial;
        logic                take;
        logic [RW-1:0]       rem_reg;
        logic [R-1:0]        root_reg;
        logic [SUM_BITS-1:0] x_reg;
        logic [TW-1:0]       tag_reg;
        logic                v_reg;

        assign rem_sh = {rem_w[k][RW-3:0], x_w[k][SUM_BITS-1 -: 2]};
        assign trial  = {1'b0, root_w[k], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_w[k][R-2:0], take};
                x_reg    <= {x_w[k][SUM_BITS-3:0], 2'b00};
                tag_reg  <= tag_w[k];
            end
        end

        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign x_w[k+1]    = x_reg;
        assign tag_w[k+1]  = tag_reg;
        assign v_w[k+1]    = v_reg;
    end

    assign out_valid = v_w[R];
    assign root      = root_w[R];
    assign out_tag   = tag_w[R];

endmodule

// ----- rtl/lav_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined three-lane rounding divider
// Computes floor((a * 2^FRAC_BITS + floor(den / 2)) / den) for three lanes
// sharing one divisor, one quotient bit per stage.
// ---------------------------------------------------------------------------
module lav_div #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int TW        = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [lav_pkg::NORM_BITS-1:0] num [3],
    input  logic [lav_pkg::ROOT_BITS-1:0] den,
    input  logic [TW-1:0]                 in_tag,
    output logic                          out_valid,
    output logic [FRAC_BITS:0]            quot [3],
    output logic [TW-1:0]                 out_tag
);
    import lav_pkg::*;

    localparam int NW = NORM_BITS + FRAC_BITS + 1;
    localparam int QB = FRAC_BITS + 1;
    localparam int RB = ROOT_BITS;

    // Entry stage: build the rounded numerators.
    logic [NW-1:0] numer [3];
    logic [RB-1:0] rem0_reg [3];
    logic [QB-1:0] lo0_reg  [3];
    logic [RB-1:0] den0_reg;
    logic [TW-1:0] tag0_reg;
    logic          v0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            numer[i] = (NW'(num[i]) << FRAC_BITS) + NW'(den >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem0_reg[i] <= {1'b0, numer[i][NW-1:QB]};
                lo0_reg[i]  <= numer[i][QB-1:0];
            end
            den0_reg <= den;
            tag0_reg <= in_tag;
        end
    end

    logic [RB-1:0] rem_w [0:QB][3];
    logic [QB-1:0] lo_w  [0:QB][3];
    logic [QB-1:0] q_w   [0:QB][3];
    logic [RB-1:0] den_w [0:QB];
    logic [TW-1:0] tag_w [0:QB];
    logic          v_w   [0:QB];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_w[0][i] = rem0_reg[i];
            lo_w[0][i]  = lo0_reg[i];
            q_w[0][i]   = '0;
        end
    end

    assign den_w[0] = den0_reg;
    assign tag_w[0] = tag0_reg;
    assign v_w[0]   = v0_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [RB:0]   rsh  [3];
        logic          ge   [3];
        logic [RB-1:0] rem_reg [3];
        logic [QB-1:0] lo_reg  [3];
        logic [QB-1:0] q_reg   [3];
        logic [RB-1:0] den_reg;
        logic [TW-1:0] tag_reg;
        logic          v_reg;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsh[i] = {rem_w[k][i], lo_w[k][i][QB-1]};
                ge[i]  = (rsh[i] >= {1'b0, den_w[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= ge[i] ? RB'(rsh[i] - {1'b0, den_w[k]}) : rsh[i][RB-1:0];
                    lo_reg[i]  <= {lo_w[k][i][QB-2:0], 1'b0};
                    q_reg[i]   <= {q_w[k][i][QB-2:0], ge[i]};
                end
                den_reg <= den_w[k];
                tag_reg <= tag_w[k];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_w[k+1][i] = rem_reg[i];
                lo_w[k+1][i]  = lo_reg[i];
                q_w[k+1][i]   = q_reg[i];
            end
        end

        assign den_w[k+1] = den_reg;
        assign tag_w[k+1] = tag_reg;
        assign v_w[k+1]   = v_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot[i] = q_w[QB][i];
        end
    end

    assign out_valid = v_w[QB];
    assign out_tag   = tag_w[QB];

endmodule

// ----- rtl/lav_norm.sv -----
// ---------------------------------------------------------------------------
// Pipelined vector normalizer
// Scales a signed integer 3-vector to unit length in fixed point; a zero
// vector gives zero and raises the degenerate flag.
// ---------------------------------------------------------------------------
module lav_norm #(
    parameter int WI        = 33,
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int TW        = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [WI-1:0]        vec [3],
    input  logic [TW-1:0]               in_tag,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] unit [3],
    output logic                        degen,
    output logic [TW-1:0]               out_tag
);
    import lav_pkg::*;

    localparam int LOG = $clog2(WI);
    localparam int SW  = TW + 4;         // {tag, zero, signs}
    localparam int SQ  = 2 * NORM_BITS;
    localparam int UW  = FRAC_BITS + 2;

    // Magnitudes and signs.
    logic [WI-1:0] mag_reg [3];
    logic [SW-1:0] sa_reg;
    logic          va_reg;
    logic          is_zero;

    assign is_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= vec[i][WI-1] ? $unsigned(-vec[i]) : $unsigned(vec[i]);
            end
            sa_reg <= {in_tag, is_zero, vec[2][WI-1], vec[1][WI-1], vec[0][WI-1]};
        end
    end

    // Leading-one alignment, one shift distance per stage. The largest
    // magnitude's top bit ends at bit WI-1; all three shift together.
    logic [WI-1:0] sh_mag  [0:LOG][3];
    logic [SW-1:0] sh_side [0:LOG];
    logic          sh_v    [0:LOG];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh_mag[0][i] = mag_reg[i];
        end
    end

    assign sh_side[0] = sa_reg;
    assign sh_v[0]    = va_reg;

    for (genvar j = 0; j < LOG; j++)
    begin : g_align
        localparam int S = 1 << (LOG - 1 - j);

        logic [WI-1:0] mor;
        logic          hit;
        logic [WI-1:0] mag_reg [3];
        logic [SW-1:0] side_reg;
        logic          v_reg;

        assign mor = sh_mag[j][0] | sh_mag[j][1] | sh_mag[j][2];
        assign hit = (mor[WI-1 -: S] == '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= sh_v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= hit ? (sh_mag[j][i] << S) : sh_mag[j][i];
                end
                side_reg <= sh_side[j];
            end
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh_mag[j+1][i] = mag_reg[i];
            end
        end

        assign sh_side[j+1] = side_reg;
        assign sh_v[j+1]    = v_reg;
    end

    // Squares of the scaled magnitudes, then their sum.
    logic [NORM_BITS-1:0] sm_q_reg [3];
    logic [SQ-1:0]        sq_reg   [3];
    logic [SW-1:0]        side_q_reg;
    logic                 vq_reg;

    logic [NORM_BITS-1:0] sm_s_reg [3];
    logic [SUM_BITS-1:0]  sum_reg;
    logic [SW-1:0]        side_s_reg;
    logic                 vs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else if (en)
        begin
            vq_reg <= sh_v[LOG];
            vs_reg <= vq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sm_q_reg[i] <= sh_mag[LOG][i][WI-1 -: NORM_BITS];
                sq_reg[i]   <= SQ'(sh_mag[LOG][i][WI-1 -: NORM_BITS])
                             * SQ'(sh_mag[LOG][i][WI-1 -: NORM_BITS]);
                sm_s_reg[i] <= sm_q_reg[i];
            end
            side_q_reg <= sh_side[LOG];
            sum_reg    <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            side_s_reg <= side_q_reg;
        end
    end

    // Length.
    localparam int QTW = 3 * NORM_BITS + SW;

    logic                 sq_v;
    logic [ROOT_BITS-1:0] len;
    logic [QTW-1:0]       sq_tag;
    logic [NORM_BITS-1:0] sm_d [3];
    logic [SW-1:0]        side_d;

    lav_sqrt #(
        .TW (QTW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs_reg),
        .radicand  (sum_reg),
        .in_tag    ({sm_s_reg[2], sm_s_reg[1], sm_s_reg[0], side_s_reg}),
        .out_valid (sq_v),
        .root      (len),
        .out_tag   (sq_tag)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sm_d[i] = sq_tag[SW + NORM_BITS * i +: NORM_BITS];
        end
    end

    assign side_d = sq_tag[SW-1:0];

    // Division of each magnitude by the length.
    logic             dv_v;
    logic [FRAC_BITS:0] q [3];
    logic [SW-1:0]    side_o;

    lav_div #(
        .FRAC_BITS (FRAC_BITS),
        .TW        (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .num       (sm_d),
        .den       (len),
        .in_tag    (side_d),
        .out_valid (dv_v),
        .quot      (q),
        .out_tag   (side_o)
    );

    // Restore signs; a zero vector forces zero.
    logic signed [UW-1:0] unit_reg [3];
    logic                 degen_reg;
    logic [TW-1:0]        tag_reg;
    logic                 vo_reg;
    logic signed [UW-1:0] qs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i] = $signed({1'b0, q[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (side_o[3])
                begin
                    unit_reg[i] <= '0;
                end
                else
                begin
                    unit_reg[i] <= side_o[i] ? -qs[i] : qs[i];
                end
            end
            degen_reg <= side_o[3];
            tag_reg   <= side_o[SW-1:4];
        end
    end

    assign out_valid = vo_reg;
    assign unit      = unit_reg;
    assign degen     = degen_reg;
    assign out_tag   = tag_reg;

endmodule

// ----- rtl/look_at_view_matrix.sv -----
// ---------------------------------------------------------------------------
// Look-at view matrix (right-handed, fixed point)
// Builds the 4x4 view matrix from eye, target and up, one row per output.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (item_valid / item_stall) carries one transaction per
// camera: eye, target and up as signed fixed point with FRAC_BITS fraction
// bits. The output channel (row_valid / row_stall) returns four
// transactions per input, rows 0 to 3 in order; last_row marks row 3 and
// degenerate is set on all four rows when the back axis or the side axis
// had zero length.
// Order: after the first row, the other rows follow on the next cycles
// unless the receiver stalls. The two normalizers dominate the depth:
// each runs a 31-stage square root and a divider with an entry stage
// and one stage per quotient bit.
// Flow: the single row port, four rows per input, sets the pace;
// inputs can enter on consecutive cycles until the pipeline backs up.
// Reset: rst_n clears all valid bits and the row sequencer; no rows are
// pending after reset.
// Stall: while rows of one matrix remain and the next finished matrix
// waits, the whole pipeline freezes and item_stall rises; nothing is lost.
// ---------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,

    output logic               row_valid,
    input  logic               row_stall,
    output lav_pkg::row_t      row_index,
    output logic signed [31:0] col0,
    output logic signed [31:0] col1,
    output logic signed [31:0] col2,
    output logic signed [31:0] col3,
    output logic               degenerate,
    output logic               last_row
);
    import lav_pkg::*;

    localparam int DW   = DATA_BITS;
    localparam int UW   = FRAC_BITS + 2;          // unit vector component
    localparam int PW   = DW + UW;                // up * z product
    localparam int CW   = PW + 1;                 // cross product up x z
    localparam int ZXW  = 2 * UW;                 // z * x product
    localparam int YDW  = ZXW + 1;                // z x x component
    localparam int YW   = FRAC_BITS + 3;          // rounded y component
    localparam int XEW  = UW + DW;                // x * eye product
    localparam int XSW  = XEW + 2;                // sum of three products
    localparam int TNW  = XSW + 1;                // negated sum
    localparam int YEW  = YW + DW;                // y * eye product
    localparam int YSW  = YEW + 2;
    localparam int YNW  = YSW + 1;
    localparam int TW1  = 6 * DW;
    localparam int TW2  = 3 * UW + 3 * DW + 1;
    localparam longint HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FRAC_BITS);

    // Global advance: everything moves unless a finished matrix waits for
    // the row sequencer.
    logic en;
    logic load;
    logic row_take;
    logic busy_reg;
    row_t cnt_reg;
    logic v6_reg;

    assign row_take   = row_valid && !row_stall;
    assign load       = v6_reg && (!busy_reg || (row_take && (cnt_reg == ROW_TRANS)));
    assign en         = !v6_reg || load;
    assign item_stall = !en;

    // -----------------------------------------------------------------------
    // Input register and back vector eye - target.
    // -----------------------------------------------------------------------
    logic signed [DW-1:0] eye_in [3];
    logic signed [DW-1:0] tgt_in [3];
    logic signed [DW-1:0] up_in  [3];

    assign eye_in = '{eye_x, eye_y, eye_z};
    assign tgt_in = '{target_x, target_y, target_z};
    assign up_in  = '{up_x, up_y, up_z};

    logic signed [DW-1:0] eye0_reg [3];
    logic signed [DW-1:0] up0_reg  [3];
    logic signed [DW:0]   d0_reg   [3];
    logic                 v0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye0_reg[i] <= eye_in[i];
                up0_reg[i]  <= up_in[i];
                d0_reg[i]   <= (DW+1)'(eye_in[i]) - (DW+1)'(tgt_in[i]);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Back axis z = norm(eye - target).
    // -----------------------------------------------------------------------
    logic                 n1_v;
    logic signed [UW-1:0] z1 [3];
    logic                 degz1;
    logic [TW1-1:0]       tag1;
    logic signed [DW-1:0] eye1 [3];
    logic signed [DW-1:0] up1  [3];

    lav_norm #(
        .WI        (DW + 1),
        .FRAC_BITS (FRAC_BITS),
        .TW        (TW1)
    ) u_norm_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .vec       (d0_reg),
        .in_tag    ({eye0_reg[2], eye0_reg[1], eye0_reg[0],
                     up0_reg[2], up0_reg[1], up0_reg[0]}),
        .out_valid (n1_v),
        .unit      (z1),
        .degen     (degz1),
        .out_tag   (tag1)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up1[i]  = $signed(tag1[DW * i +: DW]);
            eye1[i] = $signed(tag1[DW * (i + 3) +: DW]);
        end
    end

    // -----------------------------------------------------------------------
    // Cross product up x z: products, then differences.
    // -----------------------------------------------------------------------
    logic signed [PW-1:0] p1_reg   [6];
    logic signed [UW-1:0] z2_reg   [3];
    logic signed [DW-1:0] eye2_reg [3];
    logic                 degz2_reg;
    logic                 v1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg[0] <= PW'(up1[1]) * PW'(z1[2]);
            p1_reg[1] <= PW'(up1[2]) * PW'(z1[1]);
            p1_reg[2] <= PW'(up1[2]) * PW'(z1[0]);
            p1_reg[3] <= PW'(up1[0]) * PW'(z1[2]);
            p1_reg[4] <= PW'(up1[0]) * PW'(z1[1]);
            p1_reg[5] <= PW'(up1[1]) * PW'(z1[0]);
            z2_reg    <= z1;
            eye2_reg  <= eye1;
            degz2_reg <= degz1;
        end
    end

    logic signed [CW-1:0] c2_reg   [3];
    logic signed [UW-1:0] z3_reg   [3];
    logic signed [DW-1:0] eye3_reg [3];
    logic                 degz3_reg;
    logic                 v2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c2_reg[i] <= CW'(p1_reg[2 * i]) - CW'(p1_reg[2 * i + 1]);
            end
            z3_reg    <= z2_reg;
            eye3_reg  <= eye2_reg;
            degz3_reg <= degz2_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Side axis x = norm(up x z).
    // -----------------------------------------------------------------------
    logic                 n2_v;
    logic signed [UW-1:0] x4 [3];
    logic                 degx4;
    logic [TW2-1:0]       tag2;
    logic signed [UW-1:0] z4   [3];
    logic signed [DW-1:0] eye4 [3];
    logic                 degz4;

    lav_norm #(
        .WI        (CW),
        .FRAC_BITS (FRAC_BITS),
        .TW        (TW2)
    ) u_norm_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .vec       (c2_reg),
        .in_tag    ({degz3_reg, eye3_reg[2], eye3_reg[1], eye3_reg[0],
                     z3_reg[2], z3_reg[1], z3_reg[0]}),
        .out_valid (n2_v),
        .unit      (x4),
        .degen     (degx4),
        .out_tag   (tag2)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            z4[i]   = $signed(tag2[UW * i +: UW]);
            eye4[i] = $signed(tag2[3 * UW + DW * i +: DW]);
        end
    end

    assign degz4 = tag2[TW2-1];

    // -----------------------------------------------------------------------
    // Products for y = z x x and for the x and z translations.
    // -----------------------------------------------------------------------
    logic signed [ZXW-1:0] zx_reg  [6];
    logic signed [XEW-1:0] xe_reg  [3];
    logic signed [XEW-1:0] ze_reg  [3];
    logic signed [UW-1:0]  x5_reg  [3];
    logic signed [UW-1:0]  z5_reg  [3];
    logic signed [DW-1:0]  eye5_reg[3];
    logic                  dg5_reg;
    logic                  v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zx_reg[0] <= ZXW'(z4[1]) * ZXW'(x4[2]);
            zx_reg[1] <= ZXW'(z4[2]) * ZXW'(x4[1]);
            zx_reg[2] <= ZXW'(z4[2]) * ZXW'(x4[0]);
            zx_reg[3] <= ZXW'(z4[0]) * ZXW'(x4[2]);
            zx_reg[4] <= ZXW'(z4[0]) * ZXW'(x4[1]);
            zx_reg[5] <= ZXW'(z4[1]) * ZXW'(x4[0]);
            for (int i = 0; i < 3; i++)
            begin
                xe_reg[i] <= XEW'(x4[i]) * XEW'(eye4[i]);
                ze_reg[i] <= XEW'(z4[i]) * XEW'(eye4[i]);
            end
            x5_reg   <= x4;
            z5_reg   <= z4;
            eye5_reg <= eye4;
            dg5_reg  <= degz4 || degx4;
        end
    end

    // -----------------------------------------------------------------------
    // Round y and the x and z translations.
    // -----------------------------------------------------------------------
    logic signed [YDW-1:0] ydiff [3];
    logic signed [YW-1:0]  yr    [3];
    logic signed [XSW-1:0] xsum;
    logic signed [XSW-1:0] zsum;
    logic signed [TNW-1:0] xneg;
    logic signed [TNW-1:0] zneg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ydiff[i] = YDW'(zx_reg[2 * i]) - YDW'(zx_reg[2 * i + 1]) + YDW'(HALF);
            yr[i]    = YW'(ydiff[i] >>> FRAC_BITS);
        end
        xsum = XSW'(xe_reg[0]) + XSW'(xe_reg[1]) + XSW'(xe_reg[2]);
        zsum = XSW'(ze_reg[0]) + XSW'(ze_reg[1]) + XSW'(ze_reg[2]);
        xneg = TNW'(HALF) - TNW'(xsum);
        zneg = TNW'(HALF) - TNW'(zsum);
    end

    logic signed [YW-1:0] y6_reg   [3];
    logic signed [DW-1:0] t0_6_reg;
    logic signed [DW-1:0] t2_6_reg;
    logic signed [UW-1:0] x6_reg   [3];
    logic signed [UW-1:0] z6_reg   [3];
    logic signed [DW-1:0] eye6_reg [3];
    logic                 dg6_reg;
    logic                 v4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y6_reg   <= yr;
            t0_6_reg <= sat32(WIDE_BITS'(xneg >>> FRAC_BITS));
            t2_6_reg <= sat32(WIDE_BITS'(zneg >>> FRAC_BITS));
            x6_reg   <= x5_reg;
            z6_reg   <= z5_reg;
            eye6_reg <= eye5_reg;
            dg6_reg  <= dg5_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Products for the y translation.
    // -----------------------------------------------------------------------
    logic signed [YEW-1:0] ye_reg [3];
    logic signed [YW-1:0]  y7_reg [3];
    logic signed [UW-1:0]  x7_reg [3];
    logic signed [UW-1:0]  z7_reg [3];
    logic signed [DW-1:0]  t0_7_reg;
    logic signed [DW-1:0]  t2_7_reg;
    logic                  dg7_reg;
    logic                  v5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ye_reg[i] <= YEW'(y6_reg[i]) * YEW'(eye6_reg[i]);
            end
            y7_reg   <= y6_reg;
            x7_reg   <= x6_reg;
            z7_reg   <= z6_reg;
            t0_7_reg <= t0_6_reg;
            t2_7_reg <= t2_6_reg;
            dg7_reg  <= dg6_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Finished matrix register.
    // -----------------------------------------------------------------------
    logic signed [YSW-1:0] ysum;
    logic signed [YNW-1:0] yneg;

    always_comb
    begin
        ysum = YSW'(ye_reg[0]) + YSW'(ye_reg[1]) + YSW'(ye_reg[2]);
        yneg = YNW'(HALF) - YNW'(ysum);
    end

    logic signed [DW-1:0] xm_reg [3];
    logic signed [DW-1:0] ym_reg [3];
    logic signed [DW-1:0] zm_reg [3];
    logic signed [DW-1:0] tm_reg [3];
    logic                 dgm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                xm_reg[i] <= DW'(x7_reg[i]);
                ym_reg[i] <= DW'(y7_reg[i]);
                zm_reg[i] <= DW'(z7_reg[i]);
            end
            tm_reg[0] <= t0_7_reg;
            tm_reg[1] <= sat32(WIDE_BITS'(yneg >>> FRAC_BITS));
            tm_reg[2] <= t2_7_reg;
            dgm_reg   <= dg7_reg;
        end
    end

    // Valid bits for the stages outside the normalizers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= item_valid;
            v1_reg <= n1_v;
            v2_reg <= v1_reg;
            v3_reg <= n2_v;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Row sequencer: holds one matrix and sends its four rows.
    // -----------------------------------------------------------------------
    logic signed [DW-1:0] xs_reg [3];
    logic signed [DW-1:0] ys_reg [3];
    logic signed [DW-1:0] zs_reg [3];
    logic signed [DW-1:0] ts_reg [3];
    logic                 dgs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= ROW_X;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ROW_X;
        end
        else if (row_take)
        begin
            if (cnt_reg == ROW_TRANS)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xs_reg  <= xm_reg;
            ys_reg  <= ym_reg;
            zs_reg  <= zm_reg;
            ts_reg  <= tm_reg;
            dgs_reg <= dgm_reg;
        end
    end

    always_comb
    begin
        unique case (cnt_reg)
            ROW_X:
            begin
                col0 = xs_reg[0];
                col1 = ys_reg[0];
                col2 = zs_reg[0];
                col3 = '0;
            end
            ROW_Y:
            begin
                col0 = xs_reg[1];
                col1 = ys_reg[1];
                col2 = zs_reg[1];
                col3 = '0;
            end
            ROW_Z:
            begin
                col0 = xs_reg[2];
                col1 = ys_reg[2];
                col2 = zs_reg[2];
                col3 = '0;
            end
            default:
            begin
                col0 = ts_reg[0];
                col1 = ts_reg[1];
                col2 = ts_reg[2];
                col3 = ONE;
            end
        endcase
    end

    assign row_valid  = busy_reg;
    assign row_index  = cnt_reg;
    assign degenerate = dgs_reg;
    assign last_row   = (cnt_reg == ROW_TRANS);

endmodule

// ----- rtl/lav_check.sv -----
// ---------------------------------------------------------------------------
// Look-at view matrix: port checker
// Watches the row channel: row order, fixed entries, a steady degenerate flag.
// ---------------------------------------------------------------------------
module lav_check #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               row_valid,
    input logic               row_stall,
    input lav_pkg::row_t      row_index,
    input logic signed [31:0] col3,
    input logic               degenerate,
    input logic               last_row
);
    import lav_pkg::*;

    localparam logic signed [31:0] ONE = 32'(64'sd1 <<< FRAC_BITS);

    // Rows of one matrix follow each other with no gap and in order.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && !last_row
        |=> row_valid && (row_index == $past(row_index) + 2'd1))
        else $error("row sequence broken inside a matrix");

    // A new matrix always starts at row 0.
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && last_row
        |=> !row_valid || (row_index == ROW_X))
        else $error("matrix did not start at row 0");

    // The last column is fixed.
    a_col3: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (last_row ? (col3 == ONE) : (col3 == '0)))
        else $error("fixed column 3 entry is wrong");

    // The degenerate flag is the same on every row of a matrix.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && !last_row
        |=> degenerate == $past(degenerate))
        else $error("degenerate flag changed within a matrix");

endmodule

bind look_at_view_matrix lav_check #(
    .FRAC_BITS (FRAC_BITS)
) u_lav_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_valid  (row_valid),
    .row_stall  (row_stall),
    .row_index  (row_index),
    .col3       (col3),
    .degenerate (degenerate),
    .last_row   (last_row)
);

// ----- verif/look_at_view_matrix_tb.sv -----
// ---------------------------------------------------------------------------
// Look-at view matrix testbench
// Sends camera transactions (eye, target, up) with random gaps while the row
// receiver stalls at random. A built-in fixed-point predictor works out the
// four expected view matrix rows per camera. A checker compares every row
// field by field against the oldest expected row.
// ---------------------------------------------------------------------------
module look_at_view_matrix_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    // Depth from an accepted camera to its first row, with no stalls.
    localparam int LATENCY    = 2 * FRAC + 94;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int RAND_ITEMS = 450;

    typedef longint vec3_t [3];

    // One row of the view matrix as it leaves the block.
    typedef struct {
        row_t                  index;
        logic signed [31:0]    col [4];
        logic                  degen;
        logic                  last;
    } matrix_row_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic               row_valid;
    logic               row_stall;
    row_t               row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               degenerate;
    logic               last_row;

    // Rows still owed by the block, oldest first.
    matrix_row_t pending_rows [$];
    int          mismatch_count = 0;
    longint      cycle_count    = 0;

    look_at_view_matrix dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .eye_x      (eye_x),
        .eye_y      (eye_y),
        .eye_z      (eye_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .up_x       (up_x),
        .up_y       (up_y),
        .up_z       (up_z),
        .row_valid  (row_valid),
        .row_stall  (row_stall),
        .row_index  (row_index),
        .col0       (col0),
        .col1       (col1),
        .col2       (col2),
        .col3       (col3),
        .degenerate (degenerate),
        .last_row   (last_row)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // The cycle counter doubles as the watchdog for a hung pipeline.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    // Bit-by-bit integer square root, floor of the true root.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'h1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Scales the vector so its largest magnitude sits in [2^29, 2^30), takes
    // the length and divides with round to nearest. A zero vector stays zero
    // and reports zero length.
    function automatic void to_unit(input vec3_t v, output vec3_t u,
                                    output bit zero_len);
        longint unsigned mag [3];
        longint unsigned biggest;
        longint unsigned sum_sq;
        longint unsigned len;
        longint unsigned quot;
        int              nbits;
        biggest = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > biggest)
                biggest = mag[i];
        end
        zero_len = (biggest == 0);
        if (zero_len)
        begin
            u = '{0, 0, 0};
            return;
        end
        nbits = 0;
        while (nbits < 64 && (biggest >> nbits) != 0)
            nbits++;
        sum_sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (nbits > NORM_BITS)
                mag[i] = mag[i] >> (nbits - NORM_BITS);
            else
                mag[i] = mag[i] << (NORM_BITS - nbits);
            sum_sq += mag[i] * mag[i];
        end
        len = int_sqrt(sum_sq);
        for (int i = 0; i < 3; i++)
        begin
            quot = ((mag[i] << FRAC) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(quot) : longint'(quot);
        end
    endfunction

    // Drops the extra fraction bits, rounding half toward plus infinity.
    function automatic longint drop_frac(input longint x);
        return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Builds the four rows owed for one camera and queues them.
    task automatic predict_view_rows(input logic signed [31:0] cam [9]);
        vec3_t       eye, up, diff, back, side_raw, side, top, trans;
        bit          back_zero, side_zero;
        longint      cell_val [4][4];
        matrix_row_t row;
        for (int i = 0; i < 3; i++)
        begin
            eye[i]  = cam[i];
            diff[i] = longint'(cam[i]) - longint'(cam[3 + i]);
            up[i]   = cam[6 + i];
        end
        to_unit(diff, back, back_zero);
        side_raw[0] = up[1] * back[2] - up[2] * back[1];
        side_raw[1] = up[2] * back[0] - up[0] * back[2];
        side_raw[2] = up[0] * back[1] - up[1] * back[0];
        to_unit(side_raw, side, side_zero);
        top[0] = drop_frac(back[1] * side[2] - back[2] * side[1]);
        top[1] = drop_frac(back[2] * side[0] - back[0] * side[2]);
        top[2] = drop_frac(back[0] * side[1] - back[1] * side[0]);
        trans[0] = drop_frac(-(side[0] * eye[0] + side[1] * eye[1] + side[2] * eye[2]));
        trans[1] = drop_frac(-(top[0] * eye[0] + top[1] * eye[1] + top[2] * eye[2]));
        trans[2] = drop_frac(-(back[0] * eye[0] + back[1] * eye[1] + back[2] * eye[2]));
        for (int i = 0; i < 3; i++)
        begin
            cell_val[i][0] = side[i];
            cell_val[i][1] = top[i];
            cell_val[i][2] = back[i];
            cell_val[i][3] = 0;
            cell_val[3][i] = trans[i];
        end
        cell_val[3][3] = longint'(1) << FRAC;
        for (int k = 0; k < 4; k++)
        begin
            row.index = row_t'(k);
            for (int i = 0; i < 4; i++)
                row.col[i] = clamp32(cell_val[k][i]);
            row.degen = back_zero | side_zero;
            row.last  = (row_t'(k) == ROW_TRANS);
            pending_rows.push_back(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Row receiver: random stall runs, mostly short, a few long, and some
    // long stretches where it never stalls.
    // ------------------------------------------------------------------
    int  stall_run_left = 0;
    bit  stall_run_high = 1'b0;

    always @(negedge clk)
    begin
        int pick;
        if (!rst_n)
        begin
            row_stall <= 1'b0;
        end
        else
        begin
            if (stall_run_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    stall_run_high = 1'b0;
                    stall_run_left = $urandom_range(1, 12);
                end
                else if (pick < 65)
                begin
                    stall_run_high = 1'b0;
                    stall_run_left = $urandom_range(40, 120);
                end
                else if (pick < 95)
                begin
                    stall_run_high = 1'b1;
                    stall_run_left = $urandom_range(1, 3);
                end
                else
                begin
                    stall_run_high = 1'b1;
                    stall_run_left = $urandom_range(15, 40);
                end
            end
            stall_run_left--;
            row_stall <= stall_run_high;
        end
    end

    // ------------------------------------------------------------------
    // Row checker: every accepted row against the oldest expected row.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        matrix_row_t want;
        logic signed [31:0] got_col [4];
        if (rst_n && row_valid && !row_stall)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("row transaction with nothing expected: row %0d", row_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                got_col = '{col0, col1, col2, col3};
                if (row_index !== want.index)
                begin
                    $error("row_index: expected %0d, got %0d", want.index, row_index);
                    mismatch_count++;
                end
                for (int i = 0; i < 4; i++)
                begin
                    if (got_col[i] !== want.col[i])
                    begin
                        $error("col%0d (row %0d): expected %h, got %h",
                               i, want.index, want.col[i], got_col[i]);
                        mismatch_count++;
                    end
                end
                if (degenerate !== want.degen)
                begin
                    $error("degenerate (row %0d): expected %b, got %b",
                           want.index, want.degen, degenerate);
                    mismatch_count++;
                end
                if (last_row !== want.last)
                begin
                    $error("last_row (row %0d): expected %b, got %b",
                           want.index, want.last, last_row);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Camera sender
    // ------------------------------------------------------------------

    // Sends one camera transaction after a random gap and records the rows
    // it must produce once the block accepts it.
    task automatic send_camera(input logic signed [31:0] cam [9]);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 93)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(10, 40);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        eye_x      <= cam[0];
        eye_y      <= cam[1];
        eye_z      <= cam[2];
        target_x   <= cam[3];
        target_y   <= cam[4];
        target_z   <= cam[5];
        up_x       <= cam[6];
        up_y       <= cam[7];
        up_z       <= cam[8];
        do
            @(posedge clk);
        while (item_stall);
        predict_view_rows(cam);
    endtask

    task automatic wait_for_rows();
        while (pending_rows.size() != 0)
            @(posedge clk);
    endtask

    // Directed cameras: a plain camera, the corner values of the fields,
    // eye on target, up along the back axis, zero up and a translation
    // large enough to clamp.
    task automatic test_directed();
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MAX = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MIN = 32'sh8000_0000;
        send_camera('{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0});
        send_camera('{3 * ONE, 2 * ONE, -4 * ONE, ONE, -ONE, 7 * ONE, 0, ONE, 0});
        // Eye on target: every axis collapses to zero.
        send_camera('{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0});
        send_camera('{MIN, MIN, MIN, MIN, MIN, MIN, MAX, MAX, MAX});
        // Up along the back axis, then zero up.
        send_camera('{0, 4 * ONE, 0, 0, 0, 0, 0, ONE, 0});
        send_camera('{ONE, ONE, ONE, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE});
        send_camera('{ONE, 0, 2 * ONE, 0, 0, 0, 0, 0, 0});
        // Widest differences in each direction.
        send_camera('{MAX, MAX, MAX, MIN, MIN, MIN, 0, ONE, 0});
        send_camera('{MIN, MAX, MIN, MAX, MIN, MAX, MIN, MIN, MAX});
        send_camera('{MIN, 0, 0, MAX, 0, 0, 0, MIN, 0});
        // Far-away eye: the translation row saturates.
        send_camera('{MAX, MAX, MAX, MAX - ONE, MAX, MAX, 0, 0, ONE});
        send_camera('{MIN, MIN, MIN, MIN + ONE, MIN + ONE, MIN, ONE, 0, 0});
        send_camera('{1, -1, 1, 0, 0, 0, -1, 1, 1});
        send_camera('{-1, -1, -1, 0, 0, 0, MAX, MIN, 1});
        send_camera('{ONE, 0, 0, 0, 0, 0, 0, 0, MAX});
    endtask

    // Random cameras: mostly ordinary scenes, with full-range noise and a
    // share of eye-on-target, up-along-back-axis and zero-up cases.
    task automatic test_random();
        logic signed [31:0] cam [9];
        logic signed [31:0] step;
        int                 pick;
        int                 scale;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            for (int i = 0; i < 9; i++)
                cam[i] = $urandom;
            if (pick < 55)
            begin
                for (int i = 0; i < 9; i++)
                    cam[i] = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
            end
            else if (pick < 65)
            begin
                for (int i = 0; i < 3; i++)
                    cam[3 + i] = cam[i];
            end
            else if (pick < 77)
            begin
                scale = $urandom_range(1, 4);
                for (int i = 0; i < 3; i++)
                begin
                    step        = $signed($urandom_range(0, 8192)) - 4096;
                    cam[3 + i]  = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
                    cam[i]      = cam[3 + i] + step;
                    cam[6 + i]  = ((pick & 1) != 0) ? step * scale : -step * scale;
                end
            end
            else if (pick < 80)
            begin
                for (int i = 6; i < 9; i++)
                    cam[i] = 0;
            end
            send_camera(cam);
        end
    endtask

    // The sender holds off until the block has emptied, then starts again.
    task automatic test_drain_pause();
        logic signed [31:0] cam [9];
        for (int n = 0; n < 12; n++)
        begin
            for (int i = 0; i < 9; i++)
                cam[i] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            send_camera(cam);
        end
        @(negedge clk);
        item_valid <= 1'b0;
        wait_for_rows();
        for (int n = 0; n < 8; n++)
        begin
            for (int i = 0; i < 9; i++)
                cam[i] = $urandom;
            send_camera(cam);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        row_stall  = 1'b0;
        eye_x      = '0;
        eye_y      = '0;
        eye_z      = '0;
        target_x   = '0;
        target_y   = '0;
        target_z   = '0;
        up_x       = '0;
        up_y       = '0;
        up_z       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_drain_pause();
        test_random();

        @(negedge clk);
        item_valid <= 1'b0;
        wait_for_rows();
        // Any row beyond the expected ones would surface within a latency.
        repeat (LATENCY + 20) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lav_pkg.sv
rtl/lav_sqrt.sv
rtl/lav_div.sv
rtl/lav_norm.sv
rtl/look_at_view_matrix.sv
rtl/lav_check.sv
verif/look_at_view_matrix_tb.sv
